// ----- src/cti_pkg.sv -----
// Shared types, field widths and default sizes for the complex table interpolator.
package cti_pkg;

   localparam int MATERIALS_DEF = 16;
   localparam int POINTS_DEF    = 64;
   localparam int FRAC_BITS_DEF = 16;

   localparam int MAT_FIELD_W = 4;
   localparam int IDX_FIELD_W = 6;
   localparam int LENGTH_W    = 32;
   localparam int VALUE_W     = 32;
   localparam int MCOUNT_W    = 5;

   typedef enum logic {
      REQ_LOAD  = 1'b0,
      REQ_QUERY = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      STATUS_LOAD_DONE = 2'd0,
      STATUS_INTERP    = 2'd1,
      STATUS_ABSENT    = 2'd2,
      STATUS_OUTSIDE   = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN,
      S_PREP,
      S_DIV,
      S_RE_ISSUE,
      S_RE_WAIT,
      S_IM_ISSUE,
      S_IM_WAIT,
      S_RESP
   } state_type;

   typedef struct packed {
      logic [LENGTH_W-1:0]       len;
      logic signed [VALUE_W-1:0] re;
      logic signed [VALUE_W-1:0] im;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

// ----- src/cti_req_if.sv -----
// Request channel: one load or query word per handshake.
interface cti_req_if;
   logic                                  valid;
   logic                                  ready;
   cti_pkg::req_kind_type                 req_type;
   logic [cti_pkg::MAT_FIELD_W-1:0]       material;
   logic [cti_pkg::IDX_FIELD_W-1:0]       point_index;
   logic [cti_pkg::LENGTH_W-1:0]          length;
   logic signed [cti_pkg::VALUE_W-1:0]    re_value;
   logic signed [cti_pkg::VALUE_W-1:0]    im_value;
   logic                                  last_point;

   modport source (output valid, req_type, material, point_index, length, re_value, im_value,
                   last_point, input ready);
   modport sink (input valid, req_type, material, point_index, length, re_value, im_value,
                 last_point, output ready);
endinterface

// ----- src/cti_rsp_if.sv -----
// Response channel: status and interpolated complex value.
interface cti_rsp_if;
   logic                               valid;
   logic                               ready;
   cti_pkg::status_type                status;
   logic signed [cti_pkg::VALUE_W-1:0] re_out;
   logic signed [cti_pkg::VALUE_W-1:0] im_out;

   modport source (output valid, status, re_out, im_out, input ready);
   modport sink (input valid, status, re_out, im_out, output ready);
endinterface

// ----- src/cti_csr_if.sv -----
// Configuration write channel carrying the material count register.
interface cti_csr_if;
   logic                             valid;
   logic                             ready;
   logic [cti_pkg::MCOUNT_W-1:0]     material_count;

   modport source (output valid, material_count, input ready);
   modport sink (input valid, material_count, output ready);
endinterface

// ----- src/cti_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module cti_ram #(
   parameter int WIDTH = cti_pkg::ENTRY_W,
   parameter int DEPTH = cti_pkg::MATERIALS_DEF * cti_pkg::POINTS_DEF
) (
   input  logic                                      clock,
   input  logic                                      we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                          wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                          rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- src/cti_frac_div.sv -----
// Restoring divider producing the segment fraction one quotient bit per cycle.
module cti_frac_div #(
   parameter int FRAC_BITS = cti_pkg::FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [cti_pkg::LENGTH_W-1:0]  num,
   input  logic [cti_pkg::LENGTH_W-1:0]  den,
   output logic                          done,
   output logic [FRAC_BITS:0]            quot
);

   localparam int RW     = cti_pkg::LENGTH_W + 1;
   localparam int DCNT_W = $clog2(FRAC_BITS + 1);

   logic [RW-1:0]        rem_ff, rem_in;
   logic [RW-1:0]        den_ff, den_in;
   logic [FRAC_BITS:0]   q_ff, q_in;
   logic [DCNT_W-1:0]    cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic                 ge;
   logic [RW-1:0]        diff;
   logic                 last;

   assign ge   = rem_ff >= den_ff;
   assign diff = rem_ff - den_ff;
   assign last = cnt_ff == DCNT_W'(FRAC_BITS);

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = {1'b0, num};
         den_in  = {1'b0, den};
         q_in    = '0;
         cnt_in  = '0;
         busy_in = den != '0;
         done_in = den == '0;
      end else if (busy_ff) begin
         rem_in = {(ge ? diff[RW-2:0] : rem_ff[RW-2:0]), 1'b0};
         q_in   = {q_ff[FRAC_BITS-1:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

// ----- src/cti_lerp.sv -----
// Three-stage lerp unit: difference, multiply by fraction, floor shift and add.
module cti_lerp #(
   parameter int FRAC_BITS = cti_pkg::FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic signed [cti_pkg::VALUE_W-1:0] v0,
   input  logic signed [cti_pkg::VALUE_W-1:0] v1,
   input  logic [FRAC_BITS:0]                 frac,
   output logic                               out_valid,
   output logic signed [cti_pkg::VALUE_W-1:0] result
);

   localparam int VW = cti_pkg::VALUE_W;
   localparam int DW = VW + 1;
   localparam int PW = DW + FRAC_BITS + 2;

   logic signed [DW-1:0]  d1_ff, d1_in;
   logic [FRAC_BITS:0]    f1_ff;
   logic signed [VW-1:0]  v01_ff;
   logic signed [PW-1:0]  p2_ff, p2_in;
   logic signed [VW-1:0]  v02_ff;
   logic signed [PW-1:0]  sum;
   logic signed [VW-1:0]  res_ff;
   logic [2:0]            vld_ff, vld_in;

   assign d1_in  = DW'(v1) - DW'(v0);
   assign p2_in  = d1_ff * $signed({1'b0, f1_ff});
   assign sum    = (p2_ff >>> FRAC_BITS) + PW'(v02_ff);
   assign vld_in = {vld_ff[1:0], start};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
      d1_ff  <= d1_in;
      f1_ff  <= frac;
      v01_ff <= v0;
      p2_ff  <= p2_in;
      v02_ff <= v01_ff;
      res_ff <= sum[VW-1:0];
   end

   assign out_valid = vld_ff[2];
   assign result    = res_ff;

endmodule

// ----- src/complex_table_linear_interp_core.sv -----
// Top level: sequencer, breakpoint memory and point-count table of the interpolator.
//
// Words arrive on req_if. A load word writes one breakpoint (length and complex
// value) into the breakpoint memory and, with last_point set, sets that material's
// point count. A query word scans the material's segments from the first, takes
// the first one that brackets the length, divides for a Q1.FRAC_BITS fraction
// and interpolates real and imaginary parts on one shared multiplier.
// Every word gives exactly one response word on rsp_if.
// csr_if writes material_count; it is always ready. It must be written only while
// idle; the block itself does not enforce this. A load, or a query with a bad material
// or fewer than two points, goes straight to the response state; a scanned query's time
// grows with the table's point count and with FRAC_BITS, set by the one-read-per-cycle
// memory scan and the one-bit-per-cycle divider.
// One word is worked on at a time; req_if.ready is high only while idle.
// The response sits in an output register, so a new word is taken while the last
// response still waits; a stalled receiver holds the sequencer before its output.
// Reset clears the point counts, material_count and the handshakes at once; the
// breakpoint memory is not cleared and holds no meaning until loaded.
module complex_table_linear_interp_core #(
   parameter int MATERIALS = cti_pkg::MATERIALS_DEF,
   parameter int POINTS    = cti_pkg::POINTS_DEF,
   parameter int FRAC_BITS = cti_pkg::FRAC_BITS_DEF
) (
   input  logic           clock,
   input  logic           reset,
   cti_req_if.sink        req_if,
   cti_rsp_if.source      rsp_if,
   cti_csr_if.sink        csr_if
);

   localparam int SLOTS   = MATERIALS * POINTS;
   localparam int SLOT_AW = $clog2(SLOTS);
   localparam int MAT_W   = (MATERIALS > 1) ? $clog2(MATERIALS) : 1;
   localparam int IDX_W   = $clog2(POINTS);
   localparam int PCNT_W  = $clog2(POINTS + 1);
   localparam int LW      = cti_pkg::LENGTH_W;
   localparam int VW      = cti_pkg::VALUE_W;

   cti_pkg::state_type           state_ff, state_in;
   logic [cti_pkg::MCOUNT_W-1:0] mcount_ff;
   logic [PCNT_W-1:0]            pts_ff [MATERIALS];
   logic [PCNT_W-1:0]            pts_in [MATERIALS];

   logic [LW-1:0]                len_ff, len_in;
   logic [PCNT_W-1:0]            n_ff, n_in;
   logic [SLOT_AW-1:0]           base_ff, base_in;
   logic [IDX_W-1:0]             cnt_ff, cnt_in;
   logic [IDX_W-1:0]             ridx_ff, ridx_in;
   logic                         rv_ff, rv_in;
   cti_pkg::entry_type           prev_ff, prev_in;
   cti_pkg::entry_type           cur_ff, cur_in;
   cti_pkg::status_type          status_ff, status_in;
   logic signed [VW-1:0]         re_res_ff, re_res_in;
   logic signed [VW-1:0]         im_res_ff, im_res_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   cti_pkg::status_type          rsp_status_ff, rsp_status_in;
   logic signed [VW-1:0]         rsp_re_ff, rsp_re_in;
   logic signed [VW-1:0]         rsp_im_ff, rsp_im_in;

   logic                         req_fire;
   logic [MAT_W-1:0]             mat_idx;
   logic                         mat_in_range;
   logic                         idx_in_range;
   logic                         mat_ok;
   logic [PCNT_W-1:0]            pts_rd;
   logic                         too_short;
   logic [SLOT_AW-1:0]           req_base;
   logic [IDX_W-1:0]             last_idx;
   logic                         bracket;
   logic                         out_free;

   logic                         ram_we;
   logic [SLOT_AW-1:0]           ram_waddr;
   cti_pkg::entry_type           ram_wdata;
   logic [SLOT_AW-1:0]           ram_raddr;
   logic [cti_pkg::ENTRY_W-1:0]  ram_rdata;
   cti_pkg::entry_type           rd_entry;

   logic                         div_start;
   logic [LW-1:0]                div_num;
   logic [LW-1:0]                div_den;
   logic                         div_done;
   logic [FRAC_BITS:0]           frac;

   logic                         lerp_start;
   logic signed [VW-1:0]         lerp_v0;
   logic signed [VW-1:0]         lerp_v1;
   logic                         lerp_valid;
   logic signed [VW-1:0]         lerp_res;

   assign req_if.ready = state_ff == cti_pkg::S_IDLE;
   assign csr_if.ready = 1'b1;
   assign req_fire     = req_if.valid && req_if.ready;
   assign out_free     = !rsp_valid_ff || rsp_if.ready;

   assign mat_idx      = MAT_W'(req_if.material);
   assign mat_in_range = int'(req_if.material) < MATERIALS;
   assign idx_in_range = int'(req_if.point_index) < POINTS;
   assign mat_ok       = mat_in_range && ({1'b0, req_if.material} < mcount_ff);
   assign pts_rd       = pts_ff[mat_idx];
   assign too_short    = pts_rd < PCNT_W'(2);
   assign req_base     = SLOT_AW'(mat_idx) * SLOT_AW'(POINTS);
   assign last_idx     = IDX_W'(n_ff - 1'b1);
   assign rd_entry     = ram_rdata;
   assign bracket      = (len_ff >= prev_ff.len) && (len_ff <= rd_entry.len);

   assign ram_we       = req_fire && (req_if.req_type == cti_pkg::REQ_LOAD) &&
                         mat_in_range && idx_in_range;
   assign ram_waddr    = req_base + SLOT_AW'(req_if.point_index);
   assign ram_wdata    = '{len: req_if.length, re: req_if.re_value, im: req_if.im_value};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cti_pkg::S_IDLE: begin
            if (req_fire) begin
               if (req_if.req_type == cti_pkg::REQ_LOAD || !mat_ok || too_short) begin
                  state_in = cti_pkg::S_RESP;
               end else begin
                  state_in = cti_pkg::S_SCAN;
               end
            end
         end
         cti_pkg::S_SCAN: begin
            if (rv_ff && ridx_ff != '0) begin
               if (bracket) begin
                  state_in = cti_pkg::S_PREP;
               end else if (ridx_ff == last_idx) begin
                  state_in = cti_pkg::S_RESP;
               end
            end
         end
         cti_pkg::S_PREP: state_in = cti_pkg::S_DIV;
         cti_pkg::S_DIV: begin
            if (div_done) begin
               state_in = cti_pkg::S_RE_ISSUE;
            end
         end
         cti_pkg::S_RE_ISSUE: state_in = cti_pkg::S_RE_WAIT;
         cti_pkg::S_RE_WAIT: begin
            if (lerp_valid) begin
               state_in = cti_pkg::S_IM_ISSUE;
            end
         end
         cti_pkg::S_IM_ISSUE: state_in = cti_pkg::S_IM_WAIT;
         cti_pkg::S_IM_WAIT: begin
            if (lerp_valid) begin
               state_in = cti_pkg::S_RESP;
            end
         end
         cti_pkg::S_RESP: begin
            if (out_free) begin
               state_in = cti_pkg::S_IDLE;
            end
         end
         default: state_in = cti_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      pts_in        = pts_ff;
      len_in        = len_ff;
      n_in          = n_ff;
      base_in       = base_ff;
      cnt_in        = cnt_ff;
      ridx_in       = ridx_ff;
      rv_in         = rv_ff;
      prev_in       = prev_ff;
      cur_in        = cur_ff;
      status_in     = status_ff;
      re_res_in     = re_res_ff;
      im_res_in     = im_res_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_status_in = rsp_status_ff;
      rsp_re_in     = rsp_re_ff;
      rsp_im_in     = rsp_im_ff;
      ram_raddr     = base_ff + SLOT_AW'(cnt_ff);
      div_start     = 1'b0;
      div_num       = len_ff - prev_ff.len;
      div_den       = cur_ff.len - prev_ff.len;
      lerp_start    = 1'b0;
      lerp_v0       = prev_ff.re;
      lerp_v1       = cur_ff.re;
      case (state_ff)
         cti_pkg::S_IDLE: begin
            if (req_fire) begin
               len_in    = req_if.length;
               base_in   = req_base;
               n_in      = pts_rd;
               cnt_in    = '0;
               rv_in     = 1'b0;
               re_res_in = '0;
               im_res_in = '0;
               if (req_if.req_type == cti_pkg::REQ_LOAD) begin
                  status_in = cti_pkg::STATUS_LOAD_DONE;
                  if (ram_we && req_if.last_point) begin
                     pts_in[mat_idx] = PCNT_W'({1'b0, req_if.point_index} + 1'b1);
                  end
               end else if (!mat_ok) begin
                  status_in = cti_pkg::STATUS_ABSENT;
               end else if (too_short) begin
                  status_in = cti_pkg::STATUS_OUTSIDE;
               end else begin
                  status_in = cti_pkg::STATUS_INTERP;
               end
            end
         end
         cti_pkg::S_SCAN: begin
            rv_in   = 1'b1;
            ridx_in = cnt_ff;
            cnt_in  = (cnt_ff == last_idx) ? cnt_ff : cnt_ff + 1'b1;
            if (rv_ff) begin
               if (ridx_ff == '0) begin
                  prev_in = rd_entry;
               end else if (bracket) begin
                  cur_in = rd_entry;
               end else begin
                  prev_in = rd_entry;
                  if (ridx_ff == last_idx) begin
                     status_in = cti_pkg::STATUS_OUTSIDE;
                  end
               end
            end
         end
         cti_pkg::S_PREP: begin
            div_start = 1'b1;
         end
         cti_pkg::S_RE_ISSUE: begin
            lerp_start = 1'b1;
         end
         cti_pkg::S_RE_WAIT: begin
            if (lerp_valid) begin
               re_res_in = lerp_res;
            end
         end
         cti_pkg::S_IM_ISSUE: begin
            lerp_start = 1'b1;
            lerp_v0    = prev_ff.im;
            lerp_v1    = cur_ff.im;
         end
         cti_pkg::S_IM_WAIT: begin
            if (lerp_valid) begin
               im_res_in = lerp_res;
            end
         end
         cti_pkg::S_RESP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_re_in     = re_res_ff;
               rsp_im_in     = im_res_ff;
            end
         end
         default: begin
            rv_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cti_pkg::S_IDLE;
         mcount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         rv_ff        <= 1'b0;
         for (int m = 0; m < MATERIALS; m++) begin
            pts_ff[m] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rv_ff        <= rv_in;
         pts_ff       <= pts_in;
         if (csr_if.valid && csr_if.ready) begin
            mcount_ff <= csr_if.material_count;
         end
      end
      len_ff        <= len_in;
      n_ff          <= n_in;
      base_ff       <= base_in;
      cnt_ff        <= cnt_in;
      ridx_ff       <= ridx_in;
      prev_ff       <= prev_in;
      cur_ff        <= cur_in;
      status_ff     <= status_in;
      re_res_ff     <= re_res_in;
      im_res_ff     <= im_res_in;
      rsp_status_ff <= rsp_status_in;
      rsp_re_ff     <= rsp_re_in;
      rsp_im_ff     <= rsp_im_in;
   end

   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.status = rsp_status_ff;
   assign rsp_if.re_out = rsp_re_ff;
   assign rsp_if.im_out = rsp_im_ff;

   cti_ram #(
      .WIDTH (cti_pkg::ENTRY_W),
      .DEPTH (SLOTS)
   ) u_bp_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   cti_frac_div #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (frac)
   );

   cti_lerp #(
      .FRAC_BITS (FRAC_BITS)
   ) u_lerp (
      .clock     (clock),
      .reset     (reset),
      .start     (lerp_start),
      .v0        (lerp_v0),
      .v1        (lerp_v1),
      .frac      (frac),
      .out_valid (lerp_valid),
      .result    (lerp_res)
   );

endmodule

// ----- dv/tb_complex_table_linear_interp_core.sv -----
// Self-checking testbench for the complex table interpolator: directed and random loads and queries.
module tb_complex_table_linear_interp_core;
   import cti_pkg::*;

   localparam int MATS = MATERIALS_DEF;
   localparam int PTS = POINTS_DEF;
   localparam int FRAC = FRAC_BITS_DEF;
   localparam int RESET_CYCLES = 11;
   localparam int TAIL_CYCLES = 120;
   localparam int CYCLE_LIMIT = 500000;

   typedef enum {CMD_WORD, CMD_CSR, CMD_DRAIN, CMD_PACE} cmd_kind_type;

   typedef struct {
      cmd_kind_type              kind;
      req_kind_type              req_type;
      logic [MAT_FIELD_W-1:0]    material;
      logic [IDX_FIELD_W-1:0]    point_index;
      logic [LENGTH_W-1:0]       length;
      logic signed [VALUE_W-1:0] re_value;
      logic signed [VALUE_W-1:0] im_value;
      logic                      last_point;
      logic [MCOUNT_W-1:0]       mcount;
      int                        send_pct;
      int                        recv_pct;
   } cmd_type;

   typedef struct {
      status_type                status;
      logic signed [VALUE_W-1:0] re;
      logic signed [VALUE_W-1:0] im;
   } answer_type;

   logic clock;
   logic reset;

   cti_req_if req_if();
   cti_rsp_if rsp_if();
   cti_csr_if csr_if();

   complex_table_linear_interp_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   // Predicted block state.
   logic [LENGTH_W-1:0]       table_len [MATS*PTS];
   logic signed [VALUE_W-1:0] table_re [MATS*PTS];
   logic signed [VALUE_W-1:0] table_im [MATS*PTS];
   logic [6:0]                table_points [MATS];
   logic [MCOUNT_W-1:0]       queryable_mats;
   answer_type                pending_answers [$];

   // Shadow used only while planning the stimulus.
   logic [LENGTH_W-1:0] plan_len [MATS][PTS];
   bit                  plan_written [MATS][PTS];
   int                  plan_points [MATS];

   cmd_type    word_plan [$];
   cmd_type    word_on_bus;
   answer_type arrived_want;
   bit         req_free;
   bit         csr_free;
   bit         send_next;
   bit         csr_next;
   int         send_pct = 0;
   int         recv_pct = 0;
   int         errors = 0;
   int         cycle_count = 0;
   int         loads_planned = 0;
   int         queries_planned = 0;
   int         csr_planned = 0;
   int         status_seen [4];

   function automatic logic signed [VALUE_W-1:0] blend(logic signed [VALUE_W-1:0] v0,
                                                        logic signed [VALUE_W-1:0] v1,
                                                        logic [63:0] frac);
      longint step;
      step = ((longint'(v1) - longint'(v0)) * longint'(frac)) >>> FRAC;
      return VALUE_W'(longint'(v0) + step);
   endfunction

   function automatic answer_type apply_word(cmd_type w);
      answer_type a;
      int base;
      int n;
      int k;
      logic [LENGTH_W-1:0] l0;
      logic [LENGTH_W-1:0] l1;
      logic [LENGTH_W-1:0] width;
      logic [63:0] frac;
      a.status = STATUS_LOAD_DONE;
      a.re = '0;
      a.im = '0;
      base = int'(w.material) * PTS;
      if (w.req_type == REQ_LOAD) begin
         table_len[base + w.point_index] = w.length;
         table_re[base + w.point_index] = w.re_value;
         table_im[base + w.point_index] = w.im_value;
         if (w.last_point) begin
            table_points[w.material] = w.point_index + 1;
         end
      end else if (w.material >= queryable_mats) begin
         a.status = STATUS_ABSENT;
      end else begin
         a.status = STATUS_OUTSIDE;
         n = table_points[w.material];
         for (k = 0; k + 1 < n; k++) begin
            l0 = table_len[base + k];
            l1 = table_len[base + k + 1];
            if (w.length >= l0 && w.length <= l1) begin
               width = l1 - l0;
               frac = (width == 0) ? 64'd0 : ({32'd0, w.length - l0} << FRAC) / width;
               a.re = blend(table_re[base + k], table_re[base + k + 1], frac);
               a.im = blend(table_im[base + k], table_im[base + k + 1], frac);
               a.status = STATUS_INTERP;
               break;
            end
         end
      end
      return a;
   endfunction

   task automatic push_word(req_kind_type rt, int mat, int idx, logic [31:0] len,
                            logic [31:0] re, logic [31:0] im, bit last);
      cmd_type c;
      c.kind = CMD_WORD;
      c.req_type = rt;
      c.material = MAT_FIELD_W'(mat);
      c.point_index = IDX_FIELD_W'(idx);
      c.length = len;
      c.re_value = re;
      c.im_value = im;
      c.last_point = last;
      c.mcount = '0;
      c.send_pct = 0;
      c.recv_pct = 0;
      word_plan.push_back(c);
   endtask

   task automatic push_ctrl(cmd_kind_type kind, int mc, int sp, int rp);
      cmd_type c;
      c.kind = kind;
      c.req_type = REQ_LOAD;
      c.material = '0;
      c.point_index = '0;
      c.length = '0;
      c.re_value = '0;
      c.im_value = '0;
      c.last_point = 1'b0;
      c.mcount = MCOUNT_W'(mc);
      c.send_pct = sp;
      c.recv_pct = rp;
      word_plan.push_back(c);
      if (kind == CMD_CSR) begin
         csr_planned++;
      end
   endtask

   // The point count is only set once every slot below it holds a breakpoint.
   task automatic plan_load(int mat, int idx, logic [31:0] len, logic [31:0] re,
                            logic [31:0] im, bit last);
      bit full;
      int i;
      full = 1'b1;
      plan_written[mat][idx] = 1'b1;
      plan_len[mat][idx] = len;
      for (i = 0; i < idx; i++) begin
         if (!plan_written[mat][i]) begin
            full = 1'b0;
         end
      end
      if (last && full) begin
         plan_points[mat] = idx + 1;
      end else begin
         last = 1'b0;
      end
      push_word(REQ_LOAD, mat, idx, len, re, im, last);
      loads_planned++;
   endtask

   task automatic plan_query(int mat, logic [31:0] len);
      push_word(REQ_QUERY, mat, $urandom_range(PTS - 1), len, $urandom(), $urandom(),
                $urandom_range(1));
      queries_planned++;
   endtask

   function automatic logic [31:0] pick_value();
      int roll;
      roll = $urandom_range(99);
      if (roll < 10) begin
         return 32'h7FFF_FFFF;
      end
      if (roll < 20) begin
         return 32'h8000_0000;
      end
      if (roll < 40) begin
         return 32'($urandom_range(2000)) - 32'd1000;
      end
      return $urandom();
   endfunction

   function automatic logic [31:0] pick_query_len(int mat);
      int n;
      int k;
      int roll;
      logic [31:0] lo;
      logic [31:0] hi;
      n = plan_points[mat];
      if (n < 2) begin
         return $urandom();
      end
      k = $urandom_range(n - 2);
      lo = plan_len[mat][k];
      hi = plan_len[mat][k+1];
      roll = $urandom_range(99);
      if (roll < 30) begin
         return $urandom_range(1) ? lo : hi;
      end
      if (roll < 75) begin
         return $urandom_range(hi, lo);
      end
      if (roll < 85 && plan_len[mat][0] != 0) begin
         return $urandom_range(plan_len[mat][0] - 1, 0);
      end
      if (roll < 95 && plan_len[mat][n-1] != 32'hFFFF_FFFF) begin
         return $urandom_range(32'hFFFF_FFFF, plan_len[mat][n-1] + 1);
      end
      return $urandom();
   endfunction

   // Lengths rise over the full range, in small steps, with many flat segments, or at random.
   task automatic plan_table(int mat, int n);
      logic [31:0] len;
      logic [31:0] room;
      int mode;
      int i;
      mode = $urandom_range(3);
      len = (mode == 1) ? 32'($urandom_range(1000)) : 32'($urandom_range(32'h8000_0000));
      for (i = 0; i < n; i++) begin
         if (i > 0) begin
            room = (32'hFFFF_FFFF - len) / (n - i);
            case (mode)
               0: begin
                  len = len + $urandom_range(room);
               end
               1: begin
                  len = len + $urandom_range(16);
               end
               2: begin
                  if ($urandom_range(9) >= 4) begin
                     len = len + $urandom_range(room);
                  end
               end
               default: begin
                  len = $urandom();
               end
            endcase
         end
         plan_load(mat, i, len, pick_value(), pick_value(), i == n - 1);
      end
   endtask

   task automatic plan_random(int count);
      int stop;
      int roll;
      int mat;
      int n;
      stop = loads_planned + queries_planned + count;
      while (loads_planned + queries_planned < stop) begin
         roll = $urandom_range(99);
         mat = $urandom_range(MATS - 1);
         if (roll < 35) begin
            n = $urandom_range(99);
            n = (n < 80) ? $urandom_range(8, 2) : (n < 95) ? $urandom_range(PTS - 1, 9) : PTS;
            plan_table(mat, n);
            repeat ($urandom_range(6, 2)) begin
               plan_query(mat, pick_query_len(mat));
            end
         end else if (roll < 75) begin
            plan_query(mat, pick_query_len(mat));
         end else if (roll < 90) begin
            plan_load(mat, $urandom_range(PTS - 1), $urandom(), pick_value(), pick_value(),
                      $urandom_range(3) == 0);
         end else begin
            plan_query(mat, $urandom());
         end
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding.", cycle_count,
                  pending_answers.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         csr_if.valid <= 1'b0;
      end else begin
         req_free = !req_if.valid || req_if.ready;
         csr_free = !csr_if.valid || csr_if.ready;
         if (req_if.valid && req_if.ready) begin
            pending_answers.push_back(apply_word(word_on_bus));
         end
         if (csr_if.valid && csr_if.ready) begin
            queryable_mats = csr_if.material_count;
         end
         send_next = !req_free;
         csr_next = !csr_free;
         if (req_free && csr_free && word_plan.size() > 0) begin
            case (word_plan[0].kind)
               CMD_WORD: begin
                  if ($urandom_range(99) >= send_pct) begin
                     word_on_bus = word_plan.pop_front();
                     req_if.req_type <= word_on_bus.req_type;
                     req_if.material <= word_on_bus.material;
                     req_if.point_index <= word_on_bus.point_index;
                     req_if.length <= word_on_bus.length;
                     req_if.re_value <= word_on_bus.re_value;
                     req_if.im_value <= word_on_bus.im_value;
                     req_if.last_point <= word_on_bus.last_point;
                     send_next = 1'b1;
                  end
               end
               CMD_CSR: begin
                  if (pending_answers.size() == 0) begin
                     csr_if.material_count <= word_plan[0].mcount;
                     csr_next = 1'b1;
                     void'(word_plan.pop_front());
                  end
               end
               CMD_DRAIN: begin
                  if (pending_answers.size() == 0) begin
                     void'(word_plan.pop_front());
                  end
               end
               default: begin
                  send_pct = word_plan[0].send_pct;
                  recv_pct = word_plan[0].recv_pct;
                  void'(word_plan.pop_front());
               end
            endcase
         end
         req_if.valid <= send_next;
         csr_if.valid <= csr_next;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (pending_answers.size() == 0) begin
               $display("%0t: unexpected word: status %0d re_out %h im_out %h", $time,
                        rsp_if.status, rsp_if.re_out, rsp_if.im_out);
               errors++;
            end else begin
               arrived_want = pending_answers.pop_front();
               status_seen[arrived_want.status]++;
               if (rsp_if.status !== arrived_want.status) begin
                  $display("%0t: status expected %0d, got %0d", $time, arrived_want.status,
                           rsp_if.status);
                  errors++;
               end
               if (rsp_if.re_out !== arrived_want.re) begin
                  $display("%0t: re_out expected %h, got %h", $time, arrived_want.re,
                           rsp_if.re_out);
                  errors++;
               end
               if (rsp_if.im_out !== arrived_want.im) begin
                  $display("%0t: im_out expected %h, got %h", $time, arrived_want.im,
                           rsp_if.im_out);
                  errors++;
               end
            end
         end
         rsp_if.ready <= ($urandom_range(99) >= recv_pct);
      end
   end

   initial begin
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.req_type = REQ_LOAD;
      req_if.material = '0;
      req_if.point_index = '0;
      req_if.length = '0;
      req_if.re_value = '0;
      req_if.im_value = '0;
      req_if.last_point = 1'b0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.material_count = '0;
      queryable_mats = '0;
      for (int m = 0; m < MATS; m++) begin
         table_points[m] = '0;
         plan_points[m] = 0;
      end
      for (int s = 0; s < 4; s++) begin
         status_seen[s] = 0;
      end

      push_ctrl(CMD_PACE, 0, 10, 78);
      push_ctrl(CMD_CSR, 0, 0, 0);
      plan_query(0, 32'd0);
      push_ctrl(CMD_CSR, MATS, 0, 0);
      plan_load(0, 0, 32'd0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
      plan_load(0, 1, 32'h10, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
      plan_load(0, 2, 32'h10, 32'd5, -32'sd5, 1'b0);
      plan_load(0, 3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 1'b1);
      plan_query(0, 32'd0);
      plan_query(0, 32'd7);
      plan_query(0, 32'd8);
      plan_query(0, 32'h10);
      plan_query(0, 32'h11);
      plan_query(0, 32'hFFFF_FFFF);
      plan_load(15, 0, 32'd100, 32'd1, 32'd2, 1'b0);
      plan_load(15, 1, 32'd100, 32'd3, 32'd4, 1'b1);
      plan_query(15, 32'd99);
      plan_query(15, 32'd100);
      plan_query(15, 32'd101);
      plan_load(7, 0, 32'd5, 32'd9, 32'd9, 1'b1);
      plan_query(7, 32'd5);
      plan_query(3, 32'd0);
      plan_load(5, PTS - 1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);

      plan_random(90);
      push_ctrl(CMD_CSR, $urandom_range(MATS - 1, 1), 0, 0);
      plan_random(80);
      push_ctrl(CMD_DRAIN, 0, 0, 0);
      push_ctrl(CMD_PACE, 0, 78, 10);
      push_ctrl(CMD_CSR, 0, 0, 0);
      plan_random(20);
      push_ctrl(CMD_CSR, MATS, 0, 0);
      plan_random(140);
      push_ctrl(CMD_PACE, 0, 0, 0);
      push_ctrl(CMD_CSR, $urandom_range(MATS - 1, 1), 0, 0);
      plan_random(60);
      push_ctrl(CMD_CSR, MATS, 0, 0);
      plan_random(110);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      while (word_plan.size() > 0 || req_if.valid || pending_answers.size() > 0) begin
         @(posedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d loads and %0d queries under %0d material count settings and three pacing phases.",
               loads_planned, queries_planned, csr_planned);
      $display("Statuses seen: load %0d, interpolated %0d, absent %0d, outside %0d.",
               status_seen[STATUS_LOAD_DONE], status_seen[STATUS_INTERP],
               status_seen[STATUS_ABSENT], status_seen[STATUS_OUTSIDE]);
      if (errors == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
